// ===== sv/psrc_pkg.sv =====
// Package for the packed symbol rank counter: widths, defaults and shared types.
`timescale 1ns / 1ps

package psrc_pkg;

    localparam int WORD_W               = 64;
    localparam int SYMBOL_W             = 4;
    localparam int TARGET_W             = 32;
    localparam int COUNT_W              = 33;

    localparam int WORD_BITS_DEF        = 64;
    localparam int BITS_PER_SYMBOL_DEF  = 4;

    // Per-beat control carried from the lane stage to the merge stage.
    typedef struct packed {
        logic clear;   // first beat of a query: restart the count
        logic active;  // beat belongs to a running query
        logic done;    // query finished after this beat
    } psrc_ctrl_t;

endpackage

// ===== sv/packed_symbol_rank_counter_unit.sv =====
// Top level: packed symbol rank (occurrence) counter with parallel lane compare.
`timescale 1ns / 1ps
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, word, symbol,                | sink
//          | target_position, start_req                       |
//  out     | out_valid, out_ready, count, done_res            | source
//
//  One input beat per cycle sustained while the output is not stalled; each beat
//  yields exactly one output beat, via the lane stage register, then the output register.
//  All LANES symbols of a word are compared in the lane stage and summed by the
//  adder tree in the merge stage, which sets the per-beat work.
//  Reset (rst_n low, async) empties both stages; no query is active, so words
//  read as count 0 with done_res 1 until a beat with start_req.
//  A stalled output holds its beat; the input keeps taking beats while the lane
//  stage has room, so a waiting result does not block the next word.

module packed_symbol_rank_counter_unit #(
    parameter int WORD_BITS       = psrc_pkg::WORD_BITS_DEF,
    parameter int BITS_PER_SYMBOL = psrc_pkg::BITS_PER_SYMBOL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [psrc_pkg::WORD_W-1:0]     word,
    input  logic [psrc_pkg::SYMBOL_W-1:0]   symbol,
    input  logic [psrc_pkg::TARGET_W-1:0]   target_position,
    input  logic                            start_req,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [psrc_pkg::COUNT_W-1:0]    count,
    output logic                            done_res
);
    import psrc_pkg::*;

    localparam int LANES = WORD_BITS / BITS_PER_SYMBOL;

    // ---------------- query state (lane stage) ----------------
    logic [SYMBOL_W-1:0]  query_symbol_reg, query_symbol_next;
    logic [TARGET_W-1:0]  query_target_reg, query_target_next;
    logic [COUNT_W-1:0]   next_pos_reg,     next_pos_next;
    logic                 finished_reg,     finished_next;

    // ---------------- pipeline registers ----------------
    logic                 s1_valid_reg;
    psrc_ctrl_t           s1_ctrl_reg,  s1_ctrl_next;
    logic [LANES-1:0]     s1_hits_reg,  s1_hits_next;

    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   count_reg,    count_next;
    logic                 done_reg;

    logic                 in_beat;
    logic                 out_adv;

    // effective query for the current beat (start overrides latched query)
    logic [SYMBOL_W-1:0]  eff_symbol;
    logic [TARGET_W-1:0]  eff_target;
    logic [COUNT_W-1:0]   eff_pos;
    logic                 eff_active;
    logic [COUNT_W-1:0]   remaining;

    // Output register takes a new beat when empty or being drained.
    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_adv;
    assign in_beat  = in_valid && in_ready;

    assign eff_symbol = start_req ? symbol : query_symbol_reg;
    assign eff_target = start_req ? target_position : query_target_reg;
    assign eff_pos    = start_req ? '0 : next_pos_reg;
    assign eff_active = start_req || !finished_reg;

    // While a query runs the next position never passes the target,
    // so this difference is the index of the last lane still counted.
    assign remaining  = COUNT_W'(eff_target) - eff_pos;

    // ---------------- lanes ----------------
    genvar li;
    generate
        for (li = 0; li < LANES; li++) begin : g_lane
            psrc_lane #(
                .BITS_PER_SYMBOL (BITS_PER_SYMBOL),
                .LANE_IDX        (li)
            ) u_lane (
                .lane_bits (word[(LANES-1-li)*BITS_PER_SYMBOL +: BITS_PER_SYMBOL]),
                .sym       (eff_symbol),
                .remaining (remaining),
                .active    (eff_active),
                .hit       (s1_hits_next[li])
            );
        end
    endgenerate

    always_comb
    begin
        query_symbol_next = eff_symbol;
        query_target_next = eff_target;
        finished_next     = !eff_active || (remaining <= COUNT_W'(LANES - 1));
        next_pos_next     = eff_active ? (eff_pos + COUNT_W'(LANES)) : eff_pos;

        s1_ctrl_next.clear  = start_req;
        s1_ctrl_next.active = eff_active;
        s1_ctrl_next.done   = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_symbol_reg <= '0;
            query_target_reg <= '0;
            next_pos_reg     <= '0;
            finished_reg     <= 1'b1;
        end
        else if (in_beat)
        begin
            query_symbol_reg <= query_symbol_next;
            query_target_reg <= query_target_next;
            next_pos_reg     <= next_pos_next;
            finished_reg     <= finished_next;
        end
    end

    // Lane stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_hits_reg <= s1_hits_next;
        end
    end

    // ---------------- merge ----------------
    psrc_merge #(
        .LANES (LANES)
    ) u_merge (
        .hits       (s1_hits_reg),
        .ctrl       (s1_ctrl_reg),
        .count_cur  (count_reg),
        .count_next (count_next)
    );

    // Output register; count_reg doubles as the running count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b1;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                count_reg <= count_next;
                done_reg  <= s1_ctrl_reg.done;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign done_res  = done_reg;

`ifndef SYNTHESIS
    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

    // A running query never has its next position beyond the target.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !finished_reg |-> (next_pos_reg <= COUNT_W'(query_target_reg)))
        else $error("next position past target while query active");

    // Beats outside a query carry no lane hits.
    a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ctrl_reg.active) |-> (s1_hits_reg == '0))
        else $error("lane hits on inactive beat");

    // An inactive beat leaves the count unchanged.
    a_idle_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_adv && !s1_ctrl_reg.active) |=> (count_reg == $past(count_reg)))
        else $error("count changed on inactive beat");
`endif

endmodule

// ===== sv/psrc_lane.sv =====
// One lane: exact symbol compare, masked against the target position.
`timescale 1ns / 1ps

module psrc_lane #(
    parameter int BITS_PER_SYMBOL = 4,
    parameter int LANE_IDX        = 0
) (
    input  logic [BITS_PER_SYMBOL-1:0]     lane_bits,
    input  logic [psrc_pkg::SYMBOL_W-1:0]  sym,
    input  logic [psrc_pkg::COUNT_W-1:0]   remaining,
    input  logic                           active,
    output logic                           hit
);
    import psrc_pkg::*;

    // Compare at the wider of lane and symbol so an oversized symbol never matches.
    localparam int CMP_W = (BITS_PER_SYMBOL > SYMBOL_W) ? BITS_PER_SYMBOL : SYMBOL_W;

    logic [CMP_W-1:0] lane_ext;
    logic [CMP_W-1:0] sym_ext;
    logic             in_range;

    assign lane_ext = CMP_W'(lane_bits);
    assign sym_ext  = CMP_W'(sym);
    assign in_range = (remaining >= COUNT_W'(LANE_IDX));
    assign hit      = active && in_range && (lane_ext == sym_ext);

endmodule

// ===== sv/psrc_merge.sv =====
// Merge stage: adder tree over lane hits and running count update.
`timescale 1ns / 1ps

module psrc_merge #(
    parameter int LANES = 16
) (
    input  logic [LANES-1:0]              hits,
    input  psrc_pkg::psrc_ctrl_t          ctrl,
    input  logic [psrc_pkg::COUNT_W-1:0]  count_cur,
    output logic [psrc_pkg::COUNT_W-1:0]  count_next
);
    import psrc_pkg::*;

    localparam int HIT_W  = $clog2(LANES + 1);
    localparam int LEVELS = $clog2(LANES);
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic [HIT_W-1:0] node [NODES];
    logic [HIT_W-1:0] sum;

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < LANES) begin : g_used
                assign node[LEAVES-1+g] = HIT_W'(hits[g]);
            end else begin : g_pad
                assign node[LEAVES-1+g] = '0;
            end
        end
        for (g = 0; g < LEAVES - 1; g++) begin : g_node
            assign node[g] = node[2*g+1] + node[2*g+2];
        end
    endgenerate

    assign sum = node[0];

    always_comb
    begin
        if (ctrl.clear)
        begin
            count_next = COUNT_W'(sum);
        end
        else if (ctrl.active)
        begin
            count_next = count_cur + COUNT_W'(sum);
        end
        else
        begin
            count_next = count_cur;
        end
    end

endmodule
